FILE: design/has_pkg.sv
// ----------------------------------------------------------------------------
// has_pkg
// Shared types, register codes, reset values and the quarter-wave sine
// generator for the harmonic additive synthesizer.
// ----------------------------------------------------------------------------
package has_pkg;

	// default build parameters
	localparam int unsigned NUM_HARMONICS_DEF   = 8;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	// harmonic index and config port widths
	localparam int unsigned HARM_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP_LO      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMP_HI      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = 3'd4;

	// reset values
	localparam logic [31:0] PHASE_STEP_RST  = 32'd429497;
	localparam logic [31:0] START_PHASE_RST = 32'd0;
	localparam logic [63:0] AMP_LO_RST      = 64'h10A4_0831_4A3D_4A3D;
	localparam logic [63:0] AMP_HI_RST      = 64'h0189_0189_0189_0CCD;
	localparam logic [23:0] OUT_GAIN_RST    = 24'd8389;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// controller to datapath commands
	typedef struct packed {
		logic              start;     // item accepted: pick base phase, clear acc
		logic              issue;     // push one harmonic into the MAC
		logic [HARM_W-1:0] harm;      // harmonic index (h-1)
		logic              mul;       // gain partial products
		logic              sum;       // combine partial products
		logic              load_out;  // round, saturate, load output, step phase
	} has_cmd_t;

	// sin(j/Q * pi/2) in Q1.15 via a Taylor-style nested polynomial,
	// evaluated at elaboration only
	function automatic logic [14:0] quarter_sine(input int unsigned j,
		input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] s;
		x  = (64'(j) * HALF_PI_Q30) >> (tbits - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		y  = (x * t) >> 30;
		s  = (y + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[14:0];
	endfunction

endpackage

FILE: design/has_ctrl.sv
// ----------------------------------------------------------------------------
// has_ctrl
// Sequencer: steps the shared MAC over the harmonics, then the gain
// multiply, rounding and output load; owns both channel handshakes.
// ----------------------------------------------------------------------------
module has_ctrl #(
	parameter int unsigned NUM_HARMONICS = has_pkg::NUM_HARMONICS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	output logic             smp_valid,
	input  logic             smp_stall,
	output has_pkg::has_cmd_t cmd
);
	import has_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HARM  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_SUM   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [HARM_W-1:0] LAST_HARM = HARM_W'(NUM_HARMONICS - 1);
	localparam logic [HARM_W-1:0] LAST_DRAIN = HARM_W'(1);

	logic [2:0]        state_q;
	logic [HARM_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign tick_stall = (state_q != S_IDLE);
	assign smp_valid  = out_valid_q;
	assign out_free   = !out_valid_q || !smp_stall;

	always_comb begin
		cmd          = '0;
		cmd.harm     = cnt_q;
		cmd.start    = (state_q == S_IDLE) && tick_valid;
		cmd.issue    = (state_q == S_HARM);
		cmd.mul      = (state_q == S_MUL);
		cmd.sum      = (state_q == S_SUM);
		cmd.load_out = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick_valid) begin
						state_q <= S_HARM;
						cnt_q   <= '0;
					end
				end
				S_HARM: begin
					if (cnt_q == LAST_HARM) begin
						state_q <= S_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				// wait here for the product and accumulate stages to empty
				S_DRAIN: begin
					if (cnt_q == LAST_DRAIN) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/has_dp.sv
// ----------------------------------------------------------------------------
// has_dp
// Datapath: config registers, phase accumulator, sine lookup, shared
// multiply-accumulate, split gain multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module has_dp #(
	parameter int unsigned NUM_HARMONICS   = has_pkg::NUM_HARMONICS_DEF,
	parameter int unsigned SINE_TABLE_BITS = has_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  has_pkg::has_cmd_t              cmd,
	input  logic                           restart,
	input  logic                           cfg_we,
	input  logic [has_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [has_pkg::CFG_DAT_W-1:0]  cfg_data,
	output logic signed [23:0]             sample,
	output logic                           clipped
);
	import has_pkg::*;

	localparam int unsigned TB     = SINE_TABLE_BITS;
	localparam int unsigned QSIZE  = 1 << (TB - 2);
	localparam int unsigned QIDX_W = TB - 1;
	localparam int unsigned PROD_W = 33;
	localparam int unsigned ACC_W  = PROD_W + $clog2(NUM_HARMONICS) + 1;
	localparam int unsigned PH_W   = ACC_W - 18 + 25;
	localparam int unsigned P_W    = ACC_W + 25;
	localparam int unsigned V_W    = P_W - 31;

	// config registers
	logic [31:0] step_q;
	logic [31:0] start_q;
	logic [63:0] amp_lo_q;
	logic [63:0] amp_hi_q;
	logic [23:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= PHASE_STEP_RST;
			start_q  <= START_PHASE_RST;
			amp_lo_q <= AMP_LO_RST;
			amp_hi_q <= AMP_HI_RST;
			gain_q   <= OUT_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP:  step_q   <= cfg_data[31:0];
				REG_START_PHASE: start_q  <= cfg_data[31:0];
				REG_AMP_LO:      amp_lo_q <= cfg_data;
				REG_AMP_HI:      amp_hi_q <= cfg_data;
				REG_OUT_GAIN:    gain_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// quarter-wave table, entries 0..QSIZE inclusive
	logic [14:0] qtab [0:QSIZE];
	for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
		assign qtab[g] = quarter_sine(g, TB);
	end

	// phase state
	logic [31:0] base_q;
	logic [31:0] hp_q;
	logic [31:0] item_phase;
	logic [31:0] rom_phase;
	logic [1:0]  quad;
	logic [TB-3:0] ofs;
	logic [QIDX_W-1:0] qidx;
	logic [14:0] mag;
	logic signed [15:0] sine;
	logic [127:0] amp_all;

	assign item_phase = restart ? start_q : base_q;
	assign rom_phase  = hp_q + 32'h4000_0000;
	assign quad       = rom_phase[31:30];
	assign ofs        = rom_phase[31-2 -: TB-2];
	assign qidx       = quad[0] ? (QIDX_W'(QSIZE) - QIDX_W'(ofs)) : QIDX_W'(ofs);
	assign mag        = qtab[qidx];
	assign sine       = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign amp_all    = {amp_hi_q, amp_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cmd.start) begin
			base_q <= item_phase;
		end else if (cmd.load_out) begin
			base_q <= base_q + step_q;
		end
	end

	// harmonic h phase is h*base, built by repeated addition
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hp_q <= item_phase;
		end else if (cmd.issue) begin
			hp_q <= hp_q + base_q;
		end
	end

	// MAC pipeline: lookup -> product -> accumulate
	logic               v_s1;
	logic               v_s2;
	logic signed [15:0] sine_s1;
	logic [15:0]        amp_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sine_s1 <= sine;
		amp_s1  <= amp_all[{cmd.harm, 4'b0000} +: 16];
		prod_s2 <= $signed({1'b0, amp_s1}) * sine_s1;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// gain multiply in two partial products, then combine
	logic [41:0]            pl_q;
	logic signed [PH_W-1:0] ph_q;
	logic signed [P_W-1:0]  p_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pl_q <= 42'(acc_q[17:0]) * 42'(gain_q);
			ph_q <= $signed(acc_q[ACC_W-1:18]) * $signed({1'b0, gain_q});
		end
		if (cmd.sum) begin
			p_q <= (P_W'(ph_q) <<< 18) + $signed(P_W'(pl_q));
		end
	end

	// round half up to Q0.23, then saturate
	logic signed [P_W-1:0] rnd;
	logic signed [V_W-1:0] v;
	logic                  clip_hi;
	logic                  clip_lo;

	assign rnd     = p_q + $signed(P_W'(64'd1 << 30));
	assign v       = V_W'(rnd >>> 31);
	assign clip_hi = !v[V_W-1] && (|v[V_W-2:23]);
	assign clip_lo = v[V_W-1] && !(&v[V_W-2:23]);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			clipped <= clip_hi || clip_lo;
			if (clip_hi) begin
				sample <= 24'sh7F_FFFF;
			end else if (clip_lo) begin
				sample <= 24'sh80_0000;
			end else begin
				sample <= v[23:0];
			end
		end
	end

endmodule

FILE: design/harmonic_additive_synth_top.sv
// ----------------------------------------------------------------------------
// harmonic_additive_synth_top
// Additive synthesizer: one saturated Q0.23 sample per tick item.
// ----------------------------------------------------------------------------
// Each accepted tick item yields one sample, the sum of NUM_HARMONICS cosine
// harmonics of a 32-bit phase accumulator, weighted by per-harmonic Q1.15
// amplitudes and scaled by out_gain. A new item is taken only once the last
// one has loaded its output: a single shared multiply-accumulate handles one
// harmonic per cycle, followed by the pipeline drain, the gain multiply, a
// step to combine its partial products and a step to round and load the
// output register. A finished sample waits in the output register while the
// next tick item is taken. Configuration writes are always accepted
// (cfg_ready stays high) and should only be made while idle.
module harmonic_additive_synth_top #(
	parameter int unsigned NUM_HARMONICS   = has_pkg::NUM_HARMONICS_DEF,
	parameter int unsigned SINE_TABLE_BITS = has_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic                          restart,
	output logic                          smp_valid,
	input  logic                          smp_stall,
	output logic signed [23:0]            sample,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [has_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [has_pkg::CFG_DAT_W-1:0] cfg_data
);
	import has_pkg::*;

	has_cmd_t cmd;

	assign cfg_ready = 1'b1;

	has_ctrl #(
		.NUM_HARMONICS(NUM_HARMONICS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.smp_valid  (smp_valid),
		.smp_stall  (smp_stall),
		.cmd        (cmd)
	);

	has_dp #(
		.NUM_HARMONICS   (NUM_HARMONICS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.restart   (restart),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.clipped   (clipped)
	);

endmodule

FILE: design/has_checker.sv
// ----------------------------------------------------------------------------
// has_checker
// Port-level checks on the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module has_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               tick_valid,
	input logic               tick_stall,
	input logic               smp_valid,
	input logic               smp_stall,
	input logic signed [23:0] sample,
	input logic               clipped
);

	// a stalled sample stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid)
		else $error("sample item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> $stable(sample) && $stable(clipped))
		else $error("stalled sample item changed");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("tick item accepted while busy");

	// a clipped sample sits at one of the rails
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && clipped |-> (sample == 24'sh7F_FFFF || sample == 24'sh80_0000))
		else $error("clipped sample not at a rail");

endmodule

bind harmonic_additive_synth_top has_checker u_has_checker (.*);

FILE: tb/tb_harmonic_additive_synth_top.sv
// ----------------------------------------------------------------------------
// tb_harmonic_additive_synth_top
// Self-checking bench for the harmonic additive synthesizer. A queue-fed
// driver sends tick items in random bursts; a monitor stalls on its own
// pattern and checks each sample and clip flag against a cycle-free
// predictor of the eight-harmonic sum. Configuration is rewritten between
// phases, only once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_harmonic_additive_synth_top;

	import has_pkg::*;

	localparam int unsigned NUM_H    = 8;
	localparam int unsigned LUT_BITS = 10;
	localparam int unsigned LUT_SIZE = 1 << LUT_BITS;
	localparam int unsigned QTR      = LUT_SIZE / 4;
	localparam int unsigned DRAIN    = 24;	// settle time after the last sample is back

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_MID = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;

	typedef struct packed {
		logic [23:0] smp;
		logic        clip;
	} smp_exp_t;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_LONG, STALL_TOGGLE} stall_mode_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 restart    = 1'b0;
	logic                 smp_stall  = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;
	wire                  tick_stall;
	wire                  smp_valid;
	wire signed [23:0]    sample;
	wire                  clipped;
	wire                  cfg_ready;

	harmonic_additive_synth_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.restart    (restart),
		.smp_valid  (smp_valid),
		.smp_stall  (smp_stall),
		.sample     (sample),
		.clipped    (clipped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// shadow registers and phase accumulator
	logic [31:0] sh_step    = 32'd429497;
	logic [31:0] sh_start   = 32'd0;
	logic [63:0] sh_amp_lo  = 64'h10A4_0831_4A3D_4A3D;
	logic [63:0] sh_amp_hi  = 64'h0189_0189_0189_0CCD;
	logic [23:0] sh_gain    = 24'd8389;
	logic [31:0] sh_phase   = 32'd0;

	logic signed [15:0] sine_lut [LUT_SIZE];

	logic        pending_ticks [$];
	smp_exp_t    expected_samples [$];
	int          n_sent  = 0;
	int          n_taken = 0;
	int          errors  = 0;

	// first quadrant of the sine, nested polynomial in Q30
	function automatic logic [14:0] quarter_wave(input int unsigned j);
		logic [63:0]      ang;
		logic [63:0]      ang2;
		logic [63:0]      poly;
		logic [63:0]      y;
		logic [63:0]      s;
		logic [4:0][7:0]  dens;
		dens = {8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
		ang  = (64'(j) * 64'd1686629713) >> (LUT_BITS - 2);
		ang2 = (ang * ang) >> 30;
		poly = 64'd1073741824;
		for (int i = 4; i >= 0; i--) begin
			poly = 64'd1073741824 - (((ang2 * poly) >> 30) / 64'(dens[i]));
		end
		y = (ang * poly) >> 30;
		s = (y + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[14:0];
	endfunction

	function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [63:0] val);
		case (idx)
			REG_PHASE_STEP:  sh_step   = val[31:0];
			REG_START_PHASE: sh_start  = val[31:0];
			REG_AMP_LO:      sh_amp_lo = val;
			REG_AMP_HI:      sh_amp_hi = val;
			REG_OUT_GAIN:    sh_gain   = val[23:0];
			default: ;
		endcase
	endfunction

	// one tick: sum of harmonics, gain, round half up, saturate, step phase
	function automatic void synth_sample(input logic rs);
		logic [31:0]        hph;
		logic [15:0]        amp;
		logic signed [63:0] amp_s;
		logic signed [63:0] sin_s;
		logic signed [63:0] acc;
		logic signed [63:0] prod;
		logic signed [63:0] rnd;
		smp_exp_t           r;
		acc = 0;
		r.clip = 1'b0;
		if (rs) begin
			sh_phase = sh_start;
		end
		for (int h = 1; h <= NUM_H; h++) begin
			amp   = (h <= 4) ? sh_amp_lo[16*(h-1) +: 16] : sh_amp_hi[16*(h-5) +: 16];
			hph   = 32'(h) * sh_phase + 32'h4000_0000;
			amp_s = {48'd0, amp};
			sin_s = sine_lut[hph[31:32-LUT_BITS]];
			acc   = acc + amp_s * sin_s;
		end
		prod = acc * $signed({40'd0, sh_gain});
		rnd  = (prod + 64'sd1073741824) >>> 31;
		if (rnd > 64'sd8388607) begin
			rnd    = 64'sd8388607;
			r.clip = 1'b1;
		end else if (rnd < -64'sd8388608) begin
			rnd    = -64'sd8388608;
			r.clip = 1'b1;
		end
		r.smp = rnd[23:0];
		sh_phase = sh_phase + sh_step;
		expected_samples.push_back(r);
	endfunction

	// tick driver: bursts of random length, random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			restart    <= 1'b0;
		end else begin
			if (tick_valid && !tick_stall) begin
				synth_sample(restart);
				n_taken++;
			end
			if (!tick_valid || !tick_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					tick_valid <= 1'b0;
				end else if (pending_ticks.size() > 0) begin
					tick_valid <= 1'b1;
					restart    <= pending_ticks.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 8);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// sample monitor with its own stall pattern
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          hold_left  = 0;
	smp_exp_t    got_exp;

	always @(posedge clk) begin
		if (!arst_n) begin
			smp_stall <= 1'b0;
		end else begin
			if (smp_valid && !smp_stall) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual sample %0d clipped %0b",
						$time, sample, clipped);
					errors++;
				end else begin
					got_exp = expected_samples.pop_front();
					if (sample !== got_exp.smp) begin
						$display("%0t: sample mismatch, expected %0d actual %0d",
							$time, $signed(got_exp.smp), sample);
						errors++;
					end
					if (clipped !== got_exp.clip) begin
						$display("%0t: clipped mismatch, expected %0b actual %0b",
							$time, got_exp.clip, clipped);
						errors++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				smp_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:   smp_stall <= 1'b0;
					STALL_SPARSE: smp_stall <= ($urandom_range(0, 3) == 0);
					STALL_LONG: begin
						if ($urandom_range(0, 7) == 0) begin
							hold_left = $urandom_range(1, 20);
						end
						smp_stall <= (hold_left > 0);
					end
					default:      smp_stall <= ~smp_stall;
				endcase
			end
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_reg_write(idx, val);
	endtask

	// all items taken, all samples back, then let the datapath settle
	task automatic wait_drained();
		while (n_taken != n_sent || expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic enqueue(input logic rs);
		pending_ticks.push_back(rs);
		n_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin : stim
		logic [31:0]        qw;
		logic signed [15:0] v;
		logic [63:0]        amp_mask;
		int                 n_items;
		for (int k = 0; k < LUT_SIZE; k++) begin
			qw = (k / QTR) % 2 ? quarter_wave(QTR - k % QTR) : quarter_wave(k % QTR);
			v  = {1'b0, qw[14:0]};
			sine_lut[k] = ((k / QTR) >= 2) ? -v : v;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, then a restart from the reset start phase
		@(negedge clk);
		enqueue(1'b0); enqueue(1'b0); enqueue(1'b1); enqueue(1'b0);
		wait_drained();

		// all harmonics at full scale on phase zero: positive clip
		cfg_write(REG_AMP_LO, {64{1'b1}});
		cfg_write(REG_AMP_HI, {64{1'b1}});
		cfg_write(REG_OUT_GAIN, {64{1'b1}});
		cfg_write(REG_PHASE_STEP, 64'd0);
		cfg_write(REG_START_PHASE, 64'd0);
		@(negedge clk);
		enqueue(1'b1); enqueue(1'b0);
		wait_drained();

		// odd harmonics only at half cycle: negative clip
		cfg_write(REG_START_PHASE, 64'h0000_0000_8000_0000);
		cfg_write(REG_AMP_LO, 64'h0000_FFFF_0000_FFFF);
		cfg_write(REG_AMP_HI, 64'h0000_FFFF_0000_FFFF);
		@(negedge clk);
		enqueue(1'b1); enqueue(1'b0);
		wait_drained();

		// zero gain
		cfg_write(REG_OUT_GAIN, 64'd0);
		@(negedge clk);
		enqueue(1'b0);
		wait_drained();

		// largest step and start phase, phase wraps every tick
		cfg_write(REG_PHASE_STEP, {64{1'b1}});
		cfg_write(REG_START_PHASE, {64{1'b1}});
		cfg_write(REG_AMP_LO, rand64());
		cfg_write(REG_AMP_HI, rand64());
		cfg_write(REG_OUT_GAIN, {40'd0, 24'h0F_FFFF});
		@(negedge clk);
		enqueue(1'b1); enqueue(1'b0); enqueue(1'b0); enqueue(1'b1); enqueue(1'b0);
		wait_drained();

		// writes to unused indexes must change nothing; smallest nonzero gain
		cfg_write(REG_UNUSED_LO, rand64());
		cfg_write(REG_UNUSED_MID, rand64());
		cfg_write(REG_UNUSED_HI, {64{1'b1}});
		cfg_write(REG_OUT_GAIN, 64'd1);
		@(negedge clk);
		enqueue(1'b0); enqueue(1'b0); enqueue(1'b1);
		wait_drained();

		// half-cycle step, full amplitudes, gain near the clip threshold
		cfg_write(REG_PHASE_STEP, 64'h0000_0000_8000_0000);
		cfg_write(REG_START_PHASE, 64'd0);
		cfg_write(REG_AMP_LO, {64{1'b1}});
		cfg_write(REG_AMP_HI, {64{1'b1}});
		cfg_write(REG_OUT_GAIN, 64'h10_0000);
		@(negedge clk);
		enqueue(1'b1); enqueue(1'b0); enqueue(1'b0); enqueue(1'b0);
		wait_drained();

		// random phases, each with fresh settings
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 2))
				0: cfg_write(REG_PHASE_STEP, {$urandom, 32'($urandom_range(1, 2000000))});
				1: cfg_write(REG_PHASE_STEP, rand64());
				default: cfg_write(REG_PHASE_STEP, {$urandom, $urandom_range(0, 1) ?
					32'hFFFF_FFFF : 32'h8000_0000});
			endcase
			cfg_write(REG_START_PHASE, rand64());
			amp_mask = $urandom_range(0, 1) ? {64{1'b1}} : 64'h0FFF_0FFF_0FFF_0FFF;
			cfg_write(REG_AMP_LO, rand64() & amp_mask);
			cfg_write(REG_AMP_HI, rand64() & amp_mask);
			cfg_write(REG_OUT_GAIN, rand64() & ((64'd1 << $urandom_range(1, 24)) - 64'd1)
				| (rand64() & 64'hFFFF_FFFF_FF00_0000));
			if ($urandom_range(0, 3) == 0) begin
				cfg_write(REG_UNUSED_LO + 3'($urandom_range(0, 2)), rand64());
			end
			n_items = $urandom_range(80, 120);
			@(negedge clk);
			for (int i = 0; i < n_items; i++) begin
				enqueue((i == 0 && $urandom_range(0, 1)) || $urandom_range(0, 15) == 0);
			end
			wait_drained();
		end

		if (errors == 0 && expected_samples.size() == 0) begin
			$display("tb_harmonic_additive_synth_top OK");
		end else begin
			$display("tb_harmonic_additive_synth_top NOT OK");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_harmonic_additive_synth_top NOT OK");
		$finish;
	end

endmodule
